### src/cpvs_pkg.sv
`default_nettype none
package cpvs_pkg;

    localparam int VolWidth   = 8;
    localparam int LimitWidth = 9;
    localparam int IdxWidth   = 3;

    localparam logic [1:0] PWR_NONE    = 2'd0;
    localparam logic [1:0] PWR_OFF     = 2'd1;
    localparam logic [1:0] PWR_STANDBY = 2'd2;
    localparam logic [1:0] PWR_ON      = 2'd3;

    localparam logic [1:0] KIND_VOL  = 2'd0;
    localparam logic [1:0] KIND_OFF  = 2'd1;
    localparam logic [1:0] KIND_STBY = 2'd2;
    localparam logic [1:0] KIND_ON   = 2'd3;

    localparam logic       CFG_MAX_VOLUME = 1'b0;
    localparam logic       CFG_MIN_VOLUME = 1'b1;

    localparam logic signed [LimitWidth-1:0] MAX_VOLUME_RESET = 9'sd6;
    localparam logic signed [LimitWidth-1:0] MIN_VOLUME_RESET = -9'sd73;

    localparam logic [7:0] VOL_CMD_BYTE0 = 8'h05;
    localparam logic [7:0] VOL_ZERO_DB   = 8'd121;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] vol_byte;
        logic       gate;
    } job_t;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       is_last;
    } cmd_t;

    function automatic cmd_t cmd_lookup(input logic [1:0] kind,
                                        input logic [IdxWidth-1:0] idx,
                                        input logic [7:0] vol_byte);
        cmd_t c;
        c = '{byte0: 8'h00, byte1: 8'h00, is_last: 1'b1};
        unique case (kind)
            KIND_VOL:
            begin
                c = '{byte0: VOL_CMD_BYTE0, byte1: vol_byte, is_last: 1'b1};
            end
            KIND_ON:
            begin
                unique case (idx)
                    3'd0: c = '{byte0: 8'h0c, byte1: 8'h67, is_last: 1'b0};
                    3'd1: c = '{byte0: 8'h12, byte1: 8'h00, is_last: 1'b0};
                    3'd2: c = '{byte0: 8'h08, byte1: 8'h10, is_last: 1'b0};
                    3'd3: c = '{byte0: 8'h0a, byte1: 8'h00, is_last: 1'b0};
                    3'd4: c = '{byte0: 8'h0e, byte1: 8'h4a, is_last: 1'b0};
                    3'd5: c = '{byte0: 8'h10, byte1: 8'h63, is_last: 1'b0};
                    default: c = '{byte0: 8'h12, byte1: 8'h01, is_last: 1'b1};
                endcase
            end
            default:
            begin
                unique case (idx)
                    3'd0: c = '{byte0: 8'h0a, byte1: 8'h08, is_last: 1'b0};
                    3'd1: c = '{byte0: 8'h08, byte1: 8'h00, is_last: 1'b0};
                    3'd2: c = '{byte0: 8'h0c, byte1: 8'h6f, is_last: 1'b0};
                    default:
                    begin
                        c = '{byte0: 8'h0c,
                              byte1: (kind == KIND_OFF) ? 8'hff : 8'h7f,
                              is_last: 1'b1};
                    end
                endcase
            end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

### src/cpvs_req_if.sv
`default_nettype none
interface cpvs_req_if;
    import cpvs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [1:0]                 power_request;
    logic signed [VolWidth-1:0] volume_db;

    modport source (output valid, output mode, output power_request, output volume_db,
                    input ready);
    modport sink (input valid, input mode, input power_request, input volume_db,
                  output ready);
endinterface
`default_nettype wire

### src/cpvs_cmd_if.sv
`default_nettype none
interface cpvs_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] command_byte0;
    logic [7:0] command_byte1;
    logic       clock_on;
    logic       last;

    modport source (output valid, output command_byte0, output command_byte1,
                    output clock_on, output last, input ready);
    modport sink (input valid, input command_byte0, input command_byte1,
                  input clock_on, input last, output ready);
endinterface
`default_nettype wire

### src/cpvs_cfg_if.sv
`default_nettype none
interface cpvs_cfg_if;
    import cpvs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  index;
    logic [LimitWidth-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### src/cpvs_emitter.sv
`default_nettype none
module cpvs_emitter (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire cpvs_pkg::job_t job,
    output logic               free,
    cpvs_cmd_if.source         command
);
    import cpvs_pkg::*;

    logic                job_valid_reg;
    job_t                job_reg;
    logic [IdxWidth-1:0] idx_reg;
    logic                out_valid_reg;
    logic [7:0]          byte0_reg;
    logic [7:0]          byte1_reg;
    logic                clock_on_reg;
    logic                last_reg;

    cmd_t cmd;
    logic emit;

    assign cmd  = cmd_lookup(job_reg.kind, idx_reg, job_reg.vol_byte);
    assign emit = job_valid_reg && (!out_valid_reg || command.ready);
    assign free = !job_valid_reg || (emit && cmd.is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load)
        begin
            job_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (emit)
        begin
            if (cmd.is_last)
                job_valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (command.ready)
            out_valid_reg <= 1'b0;
    end

    // the off run drops the clock gate on its final command
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte0_reg    <= cmd.byte0;
            byte1_reg    <= cmd.byte1;
            clock_on_reg <= (job_reg.kind == KIND_OFF && cmd.is_last) ? 1'b0 : job_reg.gate;
            last_reg     <= cmd.is_last;
        end
    end

    assign command.valid         = out_valid_reg;
    assign command.command_byte0 = byte0_reg;
    assign command.command_byte1 = byte1_reg;
    assign command.clock_on      = clock_on_reg;
    assign command.last          = last_reg;
endmodule
`default_nettype wire

### src/codec_power_volume_sequencer_core.sv
`default_nettype none
// Channel   Role   Handshake     Payload
// request   sink   valid/ready   mode, power_request, volume_db
// command   source valid/ready   command_byte0, command_byte1, clock_on, last
// cfg       sink   valid/ready   index (0 max, 1 min volume), data
//
// One command leaves per cycle from the command table walker, unless a stalled
// command side holds the walker; an item that yields commands holds the request
// side until its last command is emitted, an item with no command does not hold
// it. The output register lets the next command be formed while the previous one
// waits. Reset clears power state, clock gate and the volume limits to defaults.
module codec_power_volume_sequencer_core (
    input  wire logic clk,
    input  wire logic rst_n,
    cpvs_req_if.sink    request,
    cpvs_cmd_if.source  command,
    cpvs_cfg_if.sink    cfg
);
    import cpvs_pkg::*;

    logic signed [LimitWidth-1:0] max_volume_reg;
    logic signed [LimitWidth-1:0] min_volume_reg;
    logic [1:0]                   power_reg;
    logic [1:0]                   power_next;
    logic                         gate_reg;
    logic                         gate_next;

    logic                         free;
    logic                         accept;
    logic                         load;
    job_t                         job;
    logic signed [LimitWidth-1:0] vol_clamped;

    assign request.ready = free;
    assign cfg.ready     = 1'b1;
    assign accept        = request.valid && free;

    always_comb
    begin
        vol_clamped = LimitWidth'(request.volume_db);
        if (vol_clamped > max_volume_reg)
            vol_clamped = max_volume_reg;
        if (vol_clamped < min_volume_reg)
            vol_clamped = min_volume_reg;
    end

    always_comb
    begin
        load          = 1'b0;
        power_next    = power_reg;
        gate_next     = gate_reg;
        job.kind      = KIND_VOL;
        job.vol_byte  = vol_clamped[7:0] + VOL_ZERO_DB;
        job.gate      = gate_reg;
        if (accept)
        begin
            if (request.mode)
                load = 1'b1;
            else if (request.power_request != PWR_NONE && request.power_request != power_reg)
            begin
                load       = 1'b1;
                power_next = request.power_request;
                job.kind   = request.power_request;
                // gate comes up before standby or on; off keeps it until the end
                if (request.power_request != PWR_OFF)
                begin
                    job.gate  = 1'b1;
                    gate_next = 1'b1;
                end
                else
                    gate_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg <= PWR_NONE;
            gate_reg  <= 1'b0;
        end
        else
        begin
            power_reg <= power_next;
            gate_reg  <= gate_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_volume_reg <= MAX_VOLUME_RESET;
            min_volume_reg <= MIN_VOLUME_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_MAX_VOLUME: max_volume_reg <= cfg.data;
                CFG_MIN_VOLUME: min_volume_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    cpvs_emitter u_emitter (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .job     (job),
        .free    (free),
        .command (command)
    );
endmodule
`default_nettype wire

### verif/codec_power_volume_sequencer_core_tb.sv
`timescale 1ns / 1ps
module codec_power_volume_sequencer_core_tb;
    import cpvs_pkg::*;

    localparam logic MODE_POWER  = 1'b0;
    localparam logic MODE_VOLUME = 1'b1;

    localparam int NUM_DIRECTED    = 22;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 55;
    localparam int IDLE_SETTLE     = 8;
    localparam int DRAIN_LIMIT     = 50000;
    localparam int HOLD_OFF_CYCLES = 200;

    // power-up and power-down command runs, first command in the top word
    localparam logic [111:0] ON_RUN = {16'h0c67, 16'h1200, 16'h0810, 16'h0a00,
                                       16'h0e4a, 16'h1063, 16'h1201};
    localparam logic [47:0] DOWN_RUN = {16'h0a08, 16'h0800, 16'h0c6f};

    typedef struct {
        logic                       mode;
        logic [1:0]                 power_request;
        logic signed [VolWidth-1:0] volume_db;
        bit                         typed;
        logic [7:0]                 typed_byte1;
        logic                       typed_clock;
    } codec_request_t;

    typedef struct {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       clock_on;
        logic       last;
    } codec_cmd_t;

    typedef enum {STALL_NONE, STALL_COIN, STALL_MASK, STALL_SPARSE} stall_kind_e;

    logic clk;
    logic rst_n;

    cpvs_req_if req_ch ();
    cpvs_cmd_if cmd_ch ();
    cpvs_cfg_if cfg_ch ();

    codec_power_volume_sequencer_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch.sink),
        .command (cmd_ch.source),
        .cfg     (cfg_ch.sink)
    );

    // mirror of the sequencer state
    logic [1:0]                   codec_power;
    logic                         gate_on;
    logic signed [LimitWidth-1:0] vol_ceiling;
    logic signed [LimitWidth-1:0] vol_floor;

    codec_request_t request_backlog[$];
    codec_cmd_t     expected_cmds[$];

    int  items_queued;
    int  items_accepted;
    int  volume_items;
    int  power_runs;
    int  commands_checked;
    int  limit_writes;
    int  fail_count;
    bit  hold_off;

    // every volume row, extremes too, is typed in; power rows use the predictor
    codec_request_t directed_rows [NUM_DIRECTED] = '{
        '{MODE_VOLUME, PWR_ON,      8'sd0,   1'b1, 8'h79, 1'b0},
        '{MODE_VOLUME, PWR_NONE,    8'sd127, 1'b1, 8'h7f, 1'b0},
        '{MODE_VOLUME, PWR_STANDBY, 8'sh80,  1'b1, 8'h30, 1'b0},
        '{MODE_VOLUME, PWR_OFF,     8'sd6,   1'b1, 8'h7f, 1'b0},
        '{MODE_VOLUME, PWR_OFF,     8'sd7,   1'b1, 8'h7f, 1'b0},
        '{MODE_VOLUME, PWR_ON,      -8'sd73, 1'b1, 8'h30, 1'b0},
        '{MODE_VOLUME, PWR_ON,      -8'sd74, 1'b1, 8'h30, 1'b0},
        '{MODE_POWER,  PWR_NONE,    8'sd0,   1'b0, 8'h00, 1'b0},
        '{MODE_POWER,  PWR_OFF,     8'sh80,  1'b0, 8'h00, 1'b0},
        '{MODE_POWER,  PWR_OFF,     8'sd127, 1'b0, 8'h00, 1'b0},
        '{MODE_POWER,  PWR_STANDBY, 8'sd127, 1'b0, 8'h00, 1'b0},
        '{MODE_VOLUME, PWR_NONE,    8'sd0,   1'b1, 8'h79, 1'b1},
        '{MODE_POWER,  PWR_STANDBY, 8'sd0,   1'b0, 8'h00, 1'b0},
        '{MODE_POWER,  PWR_ON,      -8'sd1,  1'b0, 8'h00, 1'b0},
        '{MODE_POWER,  PWR_ON,      8'sd0,   1'b0, 8'h00, 1'b0},
        '{MODE_VOLUME, PWR_STANDBY, -8'sd1,  1'b1, 8'h78, 1'b1},
        '{MODE_POWER,  PWR_NONE,    8'sd0,   1'b0, 8'h00, 1'b0},
        '{MODE_POWER,  PWR_OFF,     8'sd0,   1'b0, 8'h00, 1'b0},
        '{MODE_VOLUME, PWR_OFF,     8'sd0,   1'b1, 8'h79, 1'b0},
        '{MODE_POWER,  PWR_ON,      8'sd0,   1'b0, 8'h00, 1'b0},
        '{MODE_POWER,  PWR_STANDBY, 8'sd0,   1'b0, 8'h00, 1'b0},
        '{MODE_POWER,  PWR_OFF,     8'sd0,   1'b0, 8'h00, 1'b0}
    };

    logic signed [LimitWidth-1:0] phase_ceiling [NUM_PHASES] = '{
        9'sd134, -9'sd121, 9'sd0, 9'h100, 9'h0ff, 9'sd6, 9'sd0
    };
    logic signed [LimitWidth-1:0] phase_floor [NUM_PHASES] = '{
        -9'sd121, 9'sd134, 9'sd0, 9'h0ff, 9'h100, -9'sd73, 9'sd0
    };

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic predict_commands(input codec_request_t it);
        int         level;
        int         i;
        logic [15:0] word;
        if (it.mode == MODE_VOLUME)
        begin
            volume_items++;
            if (it.typed)
            begin
                expected_cmds.push_back('{VOL_CMD_BYTE0, it.typed_byte1, it.typed_clock, 1'b1});
            end
            else
            begin
                level = it.volume_db;
                if (level > vol_ceiling)
                    level = vol_ceiling;
                if (level < vol_floor)
                    level = vol_floor;
                expected_cmds.push_back('{VOL_CMD_BYTE0, 8'(level + int'(VOL_ZERO_DB)),
                                          gate_on, 1'b1});
            end
            return;
        end
        if (it.power_request == PWR_NONE || it.power_request == codec_power)
            return;
        power_runs++;
        if (it.power_request != PWR_OFF)
            gate_on = 1'b1;
        if (it.power_request == PWR_ON)
        begin
            for (i = 0; i < 7; i++)
            begin
                word = ON_RUN[(6 - i) * 16 +: 16];
                expected_cmds.push_back('{word[15:8], word[7:0], gate_on, 1'(i == 6)});
            end
        end
        else
        begin
            for (i = 0; i < 3; i++)
            begin
                word = DOWN_RUN[(2 - i) * 16 +: 16];
                expected_cmds.push_back('{word[15:8], word[7:0], gate_on, 1'b0});
            end
            // gate drops together with the last command of the off run
            if (it.power_request == PWR_OFF)
            begin
                gate_on = 1'b0;
                expected_cmds.push_back('{8'h0c, 8'hff, gate_on, 1'b1});
            end
            else
            begin
                expected_cmds.push_back('{8'h0c, 8'h7f, gate_on, 1'b1});
            end
        end
        codec_power = it.power_request;
    endtask

    // call right after a rising edge; leaves valid high for a following write
    task automatic write_limit(input logic idx, input logic signed [LimitWidth-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == CFG_MAX_VOLUME)
            vol_ceiling = value;
        else
            vol_floor = value;
        limit_writes++;
    endtask

    task automatic wait_for_idle();
        int guard;
        guard = 0;
        while ((items_accepted != items_queued || expected_cmds.size() != 0)
               && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (expected_cmds.size() != 0)
        begin
            $error("%0d commands never arrived", expected_cmds.size());
            fail_count++;
            expected_cmds.delete();
        end
        // let items that produce no command work their way through
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    initial
    begin : request_sender
        codec_request_t offered;
        int gap_left;
        int burst_left;
        gap_left   = 0;
        burst_left = 0;
        req_ch.valid         <= 1'b0;
        req_ch.mode          <= MODE_POWER;
        req_ch.power_request <= PWR_NONE;
        req_ch.volume_db     <= '0;
        forever
        begin
            @(posedge clk);
            if (req_ch.valid && req_ch.ready)
            begin
                predict_commands(offered);
                items_accepted++;
            end
            // hold the current transaction until it is taken
            if (!(req_ch.valid && !req_ch.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (request_backlog.size() != 0)
                begin
                    offered = request_backlog.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.mode          <= offered.mode;
                    req_ch.power_request <= offered.power_request;
                    req_ch.volume_db     <= offered.volume_db;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                        burst_left = $urandom_range(1, 24);
                    end
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    initial
    begin : command_checker
        codec_cmd_t  want;
        stall_kind_e stall_kind;
        int          pattern_left;
        logic [7:0]  stall_mask;
        logic        take;
        pattern_left = 0;
        stall_kind   = STALL_NONE;
        stall_mask   = '1;
        cmd_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && cmd_ch.valid && cmd_ch.ready)
            begin
                commands_checked++;
                if (expected_cmds.size() == 0)
                begin
                    $error("unexpected command %02h %02h", cmd_ch.command_byte0,
                           cmd_ch.command_byte1);
                    fail_count++;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (cmd_ch.command_byte0 !== want.byte0)
                    begin
                        $error("command_byte0 mismatch: expected %02h, actual %02h",
                               want.byte0, cmd_ch.command_byte0);
                        fail_count++;
                    end
                    if (cmd_ch.command_byte1 !== want.byte1)
                    begin
                        $error("command_byte1 mismatch: expected %02h, actual %02h",
                               want.byte1, cmd_ch.command_byte1);
                        fail_count++;
                    end
                    if (cmd_ch.clock_on !== want.clock_on)
                    begin
                        $error("clock_on mismatch: expected %0b, actual %0b",
                               want.clock_on, cmd_ch.clock_on);
                        fail_count++;
                    end
                    if (cmd_ch.last !== want.last)
                    begin
                        $error("last mismatch: expected %0b, actual %0b",
                               want.last, cmd_ch.last);
                        fail_count++;
                    end
                end
            end
            if (pattern_left == 0)
            begin
                stall_kind   = stall_kind_e'($urandom_range(0, 3));
                pattern_left = $urandom_range(16, 96);
                stall_mask   = 8'($urandom);
            end
            pattern_left--;
            case (stall_kind)
                STALL_NONE:   take = 1'b1;
                STALL_COIN:   take = 1'($urandom_range(0, 1));
                STALL_MASK:   take = stall_mask[pattern_left % 8];
                default:      take = ($urandom_range(0, 9) != 0);
            endcase
            cmd_ch.ready <= take && !hold_off;
        end
    end

    // long receiver hold-off so the block backs up into its request side
    initial
    begin : output_hold_off
        hold_off <= 1'b0;
        wait (items_accepted >= 120);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : watchdog
        #2000000;
        $display("codec_power_volume_sequencer_core test failed");
        $finish;
    end

    initial
    begin : main_sequence
        codec_request_t it;
        logic signed [LimitWidth-1:0] ceiling;
        logic signed [LimitWidth-1:0] floor_db;
        int p;
        int n;
        codec_power      = PWR_NONE;
        gate_on          = 1'b0;
        vol_ceiling      = MAX_VOLUME_RESET;
        vol_floor        = MIN_VOLUME_RESET;
        items_queued     = 0;
        items_accepted   = 0;
        volume_items     = 0;
        power_runs       = 0;
        commands_checked = 0;
        limit_writes     = 0;
        fail_count       = 0;
        rst_n        <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_MAX_VOLUME;
        cfg_ch.data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < NUM_DIRECTED; n++)
        begin
            request_backlog.push_back(directed_rows[n]);
            items_queued++;
        end
        wait_for_idle();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            ceiling  = phase_ceiling[p];
            floor_db = phase_floor[p];
            if (p == NUM_PHASES - 1)
            begin
                ceiling  = 9'($urandom_range(0, 511));
                floor_db = 9'($urandom_range(0, 511));
            end
            write_limit(CFG_MAX_VOLUME, ceiling);
            write_limit(CFG_MIN_VOLUME, floor_db);
            cfg_ch.valid <= 1'b0;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                it.typed       = 1'b0;
                it.typed_byte1 = '0;
                it.typed_clock = 1'b0;
                it.mode = ($urandom_range(0, 9) < 4) ? MODE_VOLUME : MODE_POWER;
                it.power_request = ($urandom_range(0, 7) == 0) ? PWR_NONE
                                                               : 2'($urandom_range(1, 3));
                case ($urandom_range(0, 5))
                    0:       it.volume_db = 8'sd127;
                    1:       it.volume_db = 8'sh80;
                    default: it.volume_db = 8'($urandom);
                endcase
                request_backlog.push_back(it);
                items_queued++;
            end
            wait_for_idle();
        end

        $display("Sent %0d requests (%0d volume, %0d power runs), checked %0d commands",
                 items_queued, volume_items, power_runs, commands_checked);
        $display("Volume limits written %0d times: reset, widest, crossed, zero, out of range",
                 limit_writes);
        if (fail_count == 0)
            $display("codec_power_volume_sequencer_core test passed");
        else
            $display("codec_power_volume_sequencer_core test failed");
        $finish;
    end

endmodule
